>>> rtl/chbd_pkg.sv
// Shared constants, codes and interface types of the canonical Huffman bit decoder.
package chbd_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int ALPHA        = 256;
  localparam int SYM_W        = $clog2(ALPHA);
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int LADDR_W      = $clog2(MAX_CODE_LEN);
  localparam int CNT_W        = $clog2(ALPHA + 1);
  localparam int LEN_IN_W     = 8;
  localparam int TOTAL_W      = 48;
  localparam int STATUS_W     = 3;
  localparam int IN_DATA_W    = ((SYM_W + LEN_IN_W + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((STATUS_W + SYM_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 3'd0,
    ST_SYMBOL   = 3'd1,
    ST_OVERLONG = 3'd2,
    ST_REJECT   = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_REBUILD,
    S_BIT,
    S_SYM
  } dec_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_CLEAR,
    T_COUNT,
    T_PREFIX,
    T_PLACE
  } tbl_state_t;

  typedef struct packed {
    logic               start;
    logic               len_we;
    logic [SYM_W-1:0]   len_addr;
    logic [LEN_W-1:0]   len_data;
    logic [LADDR_W-1:0] cnt_addr;
    logic [SYM_W-1:0]   sym_addr;
  } tbl_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] longest;
    logic [CNT_W-1:0] cnt;
    logic [SYM_W-1:0] sym;
  } tbl_rsp_t;

endpackage

>>> rtl/chbd_table.sv
// Code length store, per-length counts and the serial rebuild of the sorted symbol table.
module chbd_table (
  input  logic               clk,
  input  logic               rst,
  input  chbd_pkg::tbl_req_t req,
  output chbd_pkg::tbl_rsp_t rsp
);
  import chbd_pkg::*;

  tbl_state_t         tstate;
  tbl_state_t         tstate_next;
  logic [LEN_W-1:0]   len_mem [ALPHA];
  logic [ALPHA-1:0]   len_vld;
  logic [LEN_W-1:0]   len_raw;
  logic               len_raw_vld;
  logic [LEN_W-1:0]   len_q;
  logic [CNT_W-1:0]   cnt [MAX_CODE_LEN];
  logic [CNT_W-1:0]   slot [MAX_CODE_LEN];
  logic [SYM_W-1:0]   sorted [ALPHA];
  logic [SYM_W-1:0]   sym_q;
  logic [CNT_W-1:0]   scan;
  logic [CNT_W-1:0]   acc;
  logic               rd_v;
  logic [SYM_W-1:0]   rd_sym;
  logic [LADDR_W-1:0] len_m1;
  logic [LADDR_W-1:0] cnt_addr;
  logic [CNT_W-1:0]   cnt_rd;
  logic [CNT_W-1:0]   slot_rd;
  logic [LEN_W-1:0]   longest;
  logic               scan_end;
  logic               prefix_end;
  logic               rd_hit;
  logic               sorted_we;
  logic               done;

  assign len_q      = len_raw_vld ? len_raw : '0;
  assign len_m1     = LADDR_W'(len_q - LEN_W'(1));
  assign scan_end   = (scan == CNT_W'(ALPHA));
  assign prefix_end = (scan[LADDR_W-1:0] == LADDR_W'(MAX_CODE_LEN - 1));
  assign rd_hit     = rd_v && (len_q != '0);
  assign sorted_we  = (tstate == T_PLACE) && rd_hit;

  always_comb begin
    case (tstate)
      T_COUNT:  cnt_addr = len_m1;
      T_PREFIX: cnt_addr = scan[LADDR_W-1:0];
      default:  cnt_addr = req.cnt_addr;
    endcase
  end

  assign cnt_rd  = cnt[cnt_addr];
  assign slot_rd = slot[len_m1];

  always_ff @(posedge clk) begin
    if (req.len_we) begin
      len_mem[req.len_addr] <= req.len_data;
    end
    len_raw <= len_mem[scan[SYM_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
    end else if (req.len_we) begin
      len_vld[req.len_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    len_raw_vld <= len_vld[scan[SYM_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sorted_we) begin
      sorted[slot_rd[SYM_W-1:0]] <= rd_sym;
    end
    sym_q <= sorted[req.sym_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= T_IDLE;
    end else begin
      tstate <= tstate_next;
    end
  end

  always_comb begin
    tstate_next = tstate;
    done        = 1'b0;
    case (tstate)
      T_IDLE: begin
        if (req.start) begin
          tstate_next = T_CLEAR;
        end
      end
      T_CLEAR: begin
        tstate_next = T_COUNT;
      end
      T_COUNT: begin
        if (scan_end) begin
          tstate_next = T_PREFIX;
        end
      end
      T_PREFIX: begin
        if (prefix_end) begin
          tstate_next = T_PLACE;
        end
      end
      T_PLACE: begin
        if (scan_end) begin
          done        = 1'b1;
          tstate_next = T_IDLE;
        end
      end
      default: begin
        tstate_next = T_IDLE;
      end
    endcase
  end

  // Length reads come back in the cycle after the scan address, so the scan
  // index travels alongside as rd_sym.
  always_ff @(posedge clk) begin
    rd_v   <= ((tstate == T_COUNT) || (tstate == T_PLACE)) && !scan_end;
    rd_sym <= scan[SYM_W-1:0];
    case (tstate)
      T_CLEAR: begin
        scan    <= '0;
        acc     <= '0;
        longest <= '0;
        for (int k = 0; k < MAX_CODE_LEN; k++) begin
          cnt[k] <= '0;
        end
      end
      T_COUNT: begin
        if (rd_hit) begin
          cnt[len_m1] <= cnt_rd + CNT_W'(1);
          if (len_q > longest) begin
            longest <= len_q;
          end
        end
        scan <= scan_end ? '0 : scan + CNT_W'(1);
      end
      T_PREFIX: begin
        slot[scan[LADDR_W-1:0]] <= acc;
        acc  <= acc + cnt_rd;
        scan <= prefix_end ? '0 : scan + CNT_W'(1);
      end
      T_PLACE: begin
        if (rd_hit) begin
          slot[len_m1] <= slot_rd + CNT_W'(1);
        end
        if (!scan_end) begin
          scan <= scan + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.done    = done;
  assign rsp.longest = longest;
  assign rsp.cnt     = cnt_rd;
  assign rsp.sym     = sym_q;

endmodule

>>> rtl/canonical_huffman_bit_decoder_unit.sv
// Top level of the canonical Huffman bit decoder with stream ports and the symbol count register.
// A load transfer passes through the idle and load states and a bit transfer through the idle
// and bit states, plus the symbol state when it completes a symbol, because the sorted symbol
// memory has a registered read port. The first bit after an accepted load first rebuilds the
// tables: a clear step, a pass over the code length memory to count lengths, prefix sums over
// the per-length counts and a second pass that places symbols. Decoding walks the code one
// bit at a time, keeping only the narrow offset of the partial code from the first code of
// its length, so each bit costs one count lookup, a 10-bit compare and subtract, and a
// 48-bit compare against the symbol count. Each transfer produces exactly one result.
module canonical_huffman_bit_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [chbd_pkg::IN_DATA_W-1:0]   s_tdata,   // symbol, length, code_bit
  input  logic                             s_tuser,   // operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [chbd_pkg::OUT_DATA_W-1:0]  m_tdata,   // status, symbol_out
  output logic                             m_tlast,
  input  logic                             cfg_write,
  input  logic [chbd_pkg::TOTAL_W-1:0]     cfg_data
);
  import chbd_pkg::*;

  dec_state_t          state;
  dec_state_t          state_next;
  tbl_req_t            req;
  tbl_rsp_t            rsp;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  emitted;
  logic [TOTAL_W-1:0]  emitted_inc;
  logic                stale;
  logic [SYM_W-1:0]    in_sym;
  logic [LEN_IN_W-1:0] in_len;
  logic                in_bit;
  logic [LEN_W-1:0]    pl;
  logic [LEN_W-1:0]    pl_inc;
  logic [CNT_W-1:0]    code_ofs;
  logic [CNT_W-1:0]    sym_base;
  logic                dead;
  logic [CNT_W:0]      d;
  logic [CNT_W:0]      d_rem;
  logic                hit_c;
  logic                overlong;
  logic                done_reached;
  logic                last_q;
  logic                out_free;
  logic                out_load;
  status_t             out_status;
  logic [SYM_W-1:0]    out_symbol;
  logic                out_last;
  logic                clr_part;
  logic                clr_emit;
  logic                step_dec;
  logic                hit;
  logic                stale_set;
  logic                stale_clr;
  logic                accept;

  chbd_table u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign accept       = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;
  assign emitted_inc  = emitted + TOTAL_W'(1);
  assign done_reached = (emitted >= total);
  assign pl_inc       = pl + LEN_W'(1);
  assign overlong     = (pl_inc > rsp.longest);
  assign d            = {code_ofs, in_bit};
  assign d_rem        = d - {1'b0, rsp.cnt};
  assign hit_c        = !dead && (d < {1'b0, rsp.cnt});

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cfg_write) begin
      total <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_sym <= s_tdata[SYM_W-1:0];
      in_len <= s_tdata[SYM_W+LEN_IN_W-1:SYM_W];
      in_bit <= s_tdata[SYM_W+LEN_IN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    out_load     = 1'b0;
    out_status   = ST_NONE;
    out_symbol   = '0;
    out_last     = 1'b0;
    clr_part     = 1'b0;
    clr_emit     = 1'b0;
    step_dec     = 1'b0;
    hit          = 1'b0;
    stale_set    = 1'b0;
    stale_clr    = 1'b0;
    req          = '0;
    req.len_addr = in_sym;
    req.len_data = LEN_W'(in_len);
    req.cnt_addr = pl[LADDR_W-1:0];
    req.sym_addr = SYM_W'(sym_base + d);
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (!s_tuser) begin
            state_next = S_LOAD;
          end else if (stale) begin
            req.start  = 1'b1;
            state_next = S_REBUILD;
          end else begin
            state_next = S_BIT;
          end
        end
      end
      S_LOAD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (in_len > LEN_IN_W'(MAX_CODE_LEN)) begin
            out_status = ST_REJECT;
          end else begin
            req.len_we = 1'b1;
            clr_part   = 1'b1;
            clr_emit   = 1'b1;
            stale_set  = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_REBUILD: begin
        if (rsp.done) begin
          stale_clr  = 1'b1;
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        if (out_free) begin
          if (done_reached) begin
            out_load   = 1'b1;
            out_status = ST_DONE;
            state_next = S_IDLE;
          end else if (overlong) begin
            out_load   = 1'b1;
            out_status = ST_OVERLONG;
            clr_part   = 1'b1;
            state_next = S_IDLE;
          end else if (hit_c) begin
            hit        = 1'b1;
            clr_part   = 1'b1;
            state_next = S_SYM;
          end else begin
            out_load   = 1'b1;
            step_dec   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_SYM: begin
        out_load   = 1'b1;
        out_status = ST_SYMBOL;
        out_symbol = rsp.sym;
        out_last   = last_q;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The partial code is held as its offset from the first code of its length,
  // already reduced by that length's count. Once the offset no longer fits in
  // its CNT_W bits, no code can match and the dead flag sticks.
  always_ff @(posedge clk) begin
    if (rst) begin
      pl       <= '0;
      code_ofs <= '0;
      sym_base <= '0;
      dead     <= 1'b0;
      emitted  <= '0;
      stale    <= 1'b1;
    end else begin
      if (stale_set) begin
        stale <= 1'b1;
      end else if (stale_clr) begin
        stale <= 1'b0;
      end
      if (clr_part) begin
        pl       <= '0;
        code_ofs <= '0;
        sym_base <= '0;
        dead     <= 1'b0;
      end else if (step_dec) begin
        pl       <= pl_inc;
        code_ofs <= d_rem[CNT_W-1:0];
        dead     <= dead || d_rem[CNT_W];
        sym_base <= sym_base + rsp.cnt;
      end
      if (clr_emit) begin
        emitted <= '0;
      end else if (hit) begin
        emitted <= emitted_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      last_q <= (emitted_inc == total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'({out_symbol, out_status});
      m_tlast <= out_last;
    end
  end

  a_sym_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SYM) |-> !m_tvalid)
    else $error("Symbol result found the output register still occupied.");

  a_no_stale_decode: assert property (@(posedge clk) disable iff (rst)
    (state == S_BIT) |-> !stale)
    else $error("Bit decoded against a stale code table.");

  a_load_marks_stale: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && out_free && in_len <= LEN_IN_W'(MAX_CODE_LEN)) |=> stale)
    else $error("Accepted length load did not mark the table stale.");

  a_partial_bounded: assert property (@(posedge clk) disable iff (rst)
    !stale |-> (pl <= rsp.longest))
    else $error("Partial code length exceeds the longest code length.");

endmodule
